// ===== src/whc_pkg.sv =====
// Shared types, constants and helper functions for the WAV header check block.
package whc_pkg;

	localparam int HEADER_BYTES = 44;
	localparam int CNT_W        = 25;
	localparam int LEN_W        = 33;
	localparam int MAX_W        = 24;
	localparam int ADDR_W       = 3;

	localparam logic [CNT_W-1:0] COUNT_MAX      = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] HDR_LAST_POS   = CNT_W'(HEADER_BYTES - 1);
	localparam logic [CNT_W-1:0] HDR_BYTES_CNT  = CNT_W'(HEADER_BYTES);
	localparam logic [LEN_W-1:0] HDR_BYTES_LEN  = LEN_W'(HEADER_BYTES);
	// riff_len + 8 == data_len + 44  <=>  riff_len == data_len + 36
	localparam logic [LEN_W-1:0] RIFF_OFFSET    = LEN_W'(HEADER_BYTES - 8);
	localparam logic [MAX_W-1:0] MAX_FILE_RESET = 24'd2097152;
	localparam logic [31:0]      CRC_POLY       = 32'hEDB88320;
	localparam logic [31:0]      CRC_ONES       = 32'hFFFFFFFF;

	// Register word index (bit 2 of the byte address)
	localparam logic REG_MAX_FILE = 1'b0;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SIZE = 2'd1,
		ST_WAV  = 2'd2
	} status_t;

	// Result word, status in the low bits
	typedef struct packed {
		logic [5:0]       pad;
		logic [31:0]      crc;
		logic [MAX_W-1:0] committed;
		status_t          status;
	} result_t;

	// Expected header byte, care = 0 for the two length fields
	typedef struct packed {
		logic       care;
		logic [7:0] val;
	} hdr_exp_t;

	function automatic hdr_exp_t hdr_expect(input logic [5:0] pos);
		hdr_exp_t e;
		e = '{care: 1'b1, val: 8'h00};
		case (pos)
			6'd0:  e.val = 8'h52; // R
			6'd1:  e.val = 8'h49; // I
			6'd2:  e.val = 8'h46; // F
			6'd3:  e.val = 8'h46; // F
			6'd4, 6'd5, 6'd6, 6'd7: e.care = 1'b0;
			6'd8:  e.val = 8'h57; // W
			6'd9:  e.val = 8'h41; // A
			6'd10: e.val = 8'h56; // V
			6'd11: e.val = 8'h45; // E
			6'd12: e.val = 8'h66; // f
			6'd13: e.val = 8'h6D; // m
			6'd14: e.val = 8'h74; // t
			6'd15: e.val = 8'h20; // space
			6'd16: e.val = 8'h10; // fmt chunk size 16
			6'd20: e.val = 8'h01; // PCM
			6'd22: e.val = 8'h01; // mono
			6'd24: e.val = 8'hC0; // 24000 Hz
			6'd25: e.val = 8'h5D;
			6'd28: e.val = 8'h80; // 48000 B/s
			6'd29: e.val = 8'hBB;
			6'd32: e.val = 8'h02; // block align
			6'd34: e.val = 8'h10; // 16 bits
			6'd36: e.val = 8'h64; // d
			6'd37: e.val = 8'h61; // a
			6'd38: e.val = 8'h74; // t
			6'd39: e.val = 8'h61; // a
			6'd40, 6'd41, 6'd42, 6'd43: e.care = 1'b0;
			default: e.val = 8'h00;
		endcase
		return e;
	endfunction

	// Reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

// ===== src/wav_header_check_crc32.sv =====
// Streaming WAV header check: each file's result is registered from its final byte.
// Throughput one byte per cycle while s_tready is high; the CRC byte update and header
// compare sit between the byte counter and the result register.
// A one-entry skid behind the result register keeps s_tready high unless two results wait.
// Reset (arst_n low) clears the counter, flags, CRC and output valids; max_file_bytes
// returns to 2097152. After each final byte the per-file state returns to reset.
module wav_header_check_crc32 (
	input  logic                           clk,
	input  logic                           arst_n,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [7:0] file_byte
	input  logic                           s_tlast,  // last_byte
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [63:0]                    m_tdata,  // [1:0] status, [25:2] committed_bytes,
	                                                 // [57:26] crc_value, [63:58] zero
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [whc_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	// Configuration register
	logic [whc_pkg::MAX_W-1:0] max_file_q;
	logic                      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == whc_pkg::REG_MAX_FILE);
	assign prdata = (paddr[2] == whc_pkg::REG_MAX_FILE) ? {8'd0, max_file_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_file_q <= whc_pkg::MAX_FILE_RESET;
		end else if (cfg_wr) begin
			max_file_q <= pwdata[whc_pkg::MAX_W-1:0];
		end
	end

	// Per-file state
	logic [whc_pkg::CNT_W-1:0] count_q;
	logic [whc_pkg::LEN_W-1:0] committed_q;
	logic [31:0]               crc_q;
	logic                      hdr_ok_q;
	logic                      riff_ok_q;
	logic                      data_ok_q;
	logic [31:0]               riff_q;
	logic [23:0]               data_lo_q;

	// Result register and skid stage
	whc_pkg::result_t          out_q;
	whc_pkg::result_t          skid_q;
	logic                      out_valid_q;
	logic                      skid_valid_q;

	logic                      acc;
	logic                      in_hdr;
	logic                      is_last_hdr;
	whc_pkg::hdr_exp_t         exp_b;
	logic                      byte_ok;
	logic [31:0]               data_full;
	logic [whc_pkg::LEN_W-1:0] cmt_new;
	logic                      riff_ok_new;
	logic                      data_ok_new;
	logic                      crc_en;
	logic [31:0]               crc_nxt;
	logic [whc_pkg::CNT_W-1:0] count_nxt;
	logic [whc_pkg::LEN_W-1:0] cmt_fin;
	logic                      hdr_fin;
	logic                      riff_fin;
	logic                      data_fin;
	logic                      size_bad;
	logic                      wav_ok;
	whc_pkg::result_t          res;
	logic                      push;
	logic                      pop;

	assign s_tready = ~skid_valid_q;
	assign acc      = s_tvalid & s_tready;

	// Header position decode and byte compare
	assign in_hdr      = count_q < whc_pkg::HDR_BYTES_CNT;
	assign is_last_hdr = count_q == whc_pkg::HDR_LAST_POS;
	assign exp_b       = whc_pkg::hdr_expect(count_q[5:0]);
	assign byte_ok     = ~in_hdr | ~exp_b.care | (exp_b.val == s_tdata);

	// Length fields complete on the last header byte
	assign data_full   = {s_tdata, data_lo_q};
	assign cmt_new     = {1'b0, data_full} + whc_pkg::HDR_BYTES_LEN;
	assign riff_ok_new = {1'b0, riff_q} == ({1'b0, data_full} + whc_pkg::RIFF_OFFSET);
	assign data_ok_new = (data_full != 32'd0) & ~data_full[0];

	// CRC covers header and declared data only
	assign crc_en  = in_hdr | ({8'd0, count_q} < committed_q);
	assign crc_nxt = crc_en ? whc_pkg::crc_byte(crc_q, s_tdata) : crc_q;

	// Saturating byte count
	assign count_nxt = (count_q == whc_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;

	// Final checks, bypassing the flags when the file ends on the last header byte
	assign cmt_fin  = is_last_hdr ? cmt_new : committed_q;
	assign riff_fin = is_last_hdr ? riff_ok_new : riff_ok_q;
	assign data_fin = is_last_hdr ? data_ok_new : data_ok_q;
	assign hdr_fin  = hdr_ok_q & byte_ok;
	assign size_bad = (count_nxt < whc_pkg::HDR_BYTES_CNT) | (count_nxt > {1'b0, max_file_q});
	assign wav_ok   = hdr_fin & riff_fin & data_fin & (cmt_fin <= {8'd0, count_nxt});

	always_comb begin
		res = '0;
		if (size_bad) begin
			res.status = whc_pkg::ST_SIZE;
		end else if (!wav_ok) begin
			res.status = whc_pkg::ST_WAV;
		end else begin
			res.status    = whc_pkg::ST_OK;
			res.committed = cmt_fin[whc_pkg::MAX_W-1:0];
			res.crc       = ~crc_nxt;
		end
	end

	// Per-file state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			committed_q <= '0;
			crc_q       <= whc_pkg::CRC_ONES;
			hdr_ok_q    <= 1'b1;
			riff_ok_q   <= 1'b0;
			data_ok_q   <= 1'b0;
		end else if (acc) begin
			if (s_tlast) begin
				count_q     <= '0;
				committed_q <= '0;
				crc_q       <= whc_pkg::CRC_ONES;
				hdr_ok_q    <= 1'b1;
				riff_ok_q   <= 1'b0;
				data_ok_q   <= 1'b0;
			end else begin
				count_q  <= count_nxt;
				crc_q    <= crc_nxt;
				hdr_ok_q <= hdr_fin;
				if (is_last_hdr) begin
					committed_q <= cmt_new;
					riff_ok_q   <= riff_ok_new;
					data_ok_q   <= data_ok_new;
				end
			end
		end
	end

	// Length field capture (no reset needed)
	always_ff @(posedge clk) begin
		if (acc && count_q[whc_pkg::CNT_W-1:3] == '0 && count_q[2]) begin
			riff_q[count_q[1:0]*8 +: 8] <= s_tdata;
		end
		if (acc && count_q >= 25'd40 && count_q <= 25'd42) begin
			data_lo_q[count_q[1:0]*8 +: 8] <= s_tdata;
		end
	end

	// Result register with skid stage
	assign push = acc & s_tlast;
	assign pop  = out_valid_q & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// Assertions
	a_skid_behind_out : assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while the output register is empty");

	a_fail_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.status != whc_pkg::ST_OK) |-> (out_q.committed == '0 && out_q.crc == '0))
		else $error("failed result carries a length or CRC");

	a_clear_after_last : assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> (count_q == '0 && crc_q == whc_pkg::CRC_ONES))
		else $error("file state not cleared after final byte");

	a_no_commit_in_hdr : assert property (@(posedge clk) disable iff (!arst_n)
		(count_q < whc_pkg::HDR_BYTES_CNT) |-> (committed_q == '0))
		else $error("committed length set before the header is complete");

endmodule

// ===== tb/wav_header_check_crc32_checker.sv =====
// Checker for the WAV header check block: predicts each file's verdict and compares results.
module wav_header_check_crc32_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [7:0]                 s_tdata,  // [7:0] file_byte
	input  logic                       s_tlast,  // last_byte
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [63:0]                m_tdata,  // [1:0] status, [25:2] committed_bytes,
	                                             // [57:26] crc_value, [63:58] zero
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [whc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output int                         mismatches,
	output int                         pending_results
);

	// Header tags as little-endian words
	localparam logic [31:0] TAG_RIFF      = 32'h4646_4952; // "RIFF"
	localparam logic [31:0] TAG_WAVE      = 32'h4556_4157; // "WAVE"
	localparam logic [31:0] TAG_FMT       = 32'h2074_6D66; // "fmt "
	localparam logic [31:0] TAG_DATA      = 32'h6174_6164; // "data"
	localparam logic [31:0] FMT_CHUNK_LEN = 32'd16;
	localparam logic [31:0] RATE_HZ       = 32'd24000;
	localparam logic [31:0] AVG_BPS       = 32'd48000;
	localparam logic [15:0] FMT_PCM       = 16'd1;
	localparam logic [15:0] CHANNELS      = 16'd1;
	localparam logic [15:0] FRAME_BYTES   = 16'd2;
	localparam logic [15:0] SAMPLE_BITS   = 16'd16;

	logic [whc_pkg::MAX_W-1:0] size_limit = whc_pkg::MAX_FILE_RESET;
	logic [whc_pkg::CNT_W-1:0] file_pos = '0;
	logic [7:0]                hdr_copy [whc_pkg::HEADER_BYTES];
	logic [whc_pkg::LEN_W-1:0] commit_len = '0;
	logic [31:0]               crc_acc = whc_pkg::CRC_ONES;
	whc_pkg::result_t          verdict_q [$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s got %h, predicted %h", $time, what, got, want);
		mismatches++;
	endtask

	// Bitwise reflected CRC-32 over one byte, LSB first
	function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] d);
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ d[i])
				c = (c >> 1) ^ whc_pkg::CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	function automatic logic [15:0] le16(input int pos);
		return {hdr_copy[pos + 1], hdr_copy[pos]};
	endfunction

	function automatic logic [31:0] le32(input int pos);
		return {hdr_copy[pos + 3], hdr_copy[pos + 2], hdr_copy[pos + 1], hdr_copy[pos]};
	endfunction

	// Canonical 16-bit mono 24 kHz PCM header with consistent lengths that fit the file
	function automatic logic wav_ok();
		logic [31:0]               dlen;
		logic [whc_pkg::LEN_W-1:0] riff_total;
		logic [whc_pkg::LEN_W-1:0] data_total;
		dlen = le32(40);
		riff_total = {1'b0, le32(4)} + whc_pkg::LEN_W'(8);
		data_total = {1'b0, dlen} + whc_pkg::HDR_BYTES_LEN;
		return le32(0) == TAG_RIFF && le32(8) == TAG_WAVE && le32(12) == TAG_FMT &&
			le32(36) == TAG_DATA && le32(16) == FMT_CHUNK_LEN && le16(20) == FMT_PCM &&
			le16(22) == CHANNELS && le32(24) == RATE_HZ && le32(28) == AVG_BPS &&
			le16(32) == FRAME_BYTES && le16(34) == SAMPLE_BITS && dlen != 32'd0 &&
			!dlen[0] && riff_total == data_total &&
			data_total <= whc_pkg::LEN_W'(file_pos);
	endfunction

	task automatic clear_file();
		file_pos = '0;
		commit_len = '0;
		crc_acc = whc_pkg::CRC_ONES;
	endtask

	// Per-byte file model; queues a verdict on the final byte
	task automatic absorb_file_byte(input logic [7:0] b, input logic fin);
		whc_pkg::result_t want;
		if (file_pos < whc_pkg::HDR_BYTES_CNT) begin
			hdr_copy[file_pos] = b;
			crc_acc = crc32_update(crc_acc, b);
			if (file_pos == whc_pkg::HDR_LAST_POS)
				commit_len = {1'b0, le32(40)} + whc_pkg::HDR_BYTES_LEN;
		end else if (whc_pkg::LEN_W'(file_pos) < commit_len) begin
			crc_acc = crc32_update(crc_acc, b);
		end
		// byte count saturates
		if (file_pos != whc_pkg::COUNT_MAX)
			file_pos++;
		if (fin) begin
			want = '0;
			if (file_pos < whc_pkg::HDR_BYTES_CNT ||
					file_pos > whc_pkg::CNT_W'(size_limit)) begin
				want.status = whc_pkg::ST_SIZE;
			end else if (!wav_ok()) begin
				want.status = whc_pkg::ST_WAV;
			end else begin
				want.status = whc_pkg::ST_OK;
				want.committed = commit_len[whc_pkg::MAX_W-1:0];
				want.crc = ~crc_acc;
			end
			verdict_q.push_back(want);
			clear_file();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		whc_pkg::result_t got;
		whc_pkg::result_t want;
		if (!arst_n) begin
			size_limit = whc_pkg::MAX_FILE_RESET;
			clear_file();
			verdict_q.delete();
			pending_results = 0;
		end else begin
			// register write transaction
			if (psel && penable && pwrite && pready && paddr[2] == whc_pkg::REG_MAX_FILE)
				size_limit = pwdata[whc_pkg::MAX_W-1:0];
			// result transaction against the oldest verdict
			if (m_tvalid && m_tready) begin
				got = whc_pkg::result_t'(m_tdata);
				if (verdict_q.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
				end else begin
					want = verdict_q.pop_front();
					if (got.status != want.status)
						report_mismatch("status", 32'(got.status), 32'(want.status));
					if (got.committed != want.committed)
						report_mismatch("committed_bytes", 32'(got.committed),
							32'(want.committed));
					if (got.crc != want.crc)
						report_mismatch("crc_value", got.crc, want.crc);
					if (got.pad != '0)
						report_mismatch("padding", 32'(got.pad), 32'd0);
				end
			end
			// input transaction
			if (s_tvalid && s_tready)
				absorb_file_byte(s_tdata, s_tlast);
			pending_results = verdict_q.size();
		end
	end

endmodule

// ===== tb/wav_header_check_crc32_tb.sv =====
// Testbench top for the WAV header check block: clock, reset, file stimulus and verdict.
module wav_header_check_crc32_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASE_BYTES    = 180;
	localparam int PHASE_FILES    = 3;
	localparam logic [whc_pkg::ADDR_W-1:0] MAX_FILE_ADDR = {whc_pkg::REG_MAX_FILE, 2'b00};

	localparam logic [31:0] TAG_RIFF  = 32'h4646_4952; // "RIFF"
	localparam logic [31:0] TAG_WAVE  = 32'h4556_4157; // "WAVE"
	localparam logic [31:0] TAG_FMT   = 32'h2074_6D66; // "fmt "
	localparam logic [31:0] TAG_DATA  = 32'h6174_6164; // "data"
	localparam logic [31:0] RATE_HZ   = 32'd24000;
	localparam logic [31:0] AVG_BPS   = 32'd48000;

	// Ways to spoil an otherwise good file
	typedef enum int {
		DMG_BIT_FLIP,
		DMG_ODD_LEN,
		DMG_ZERO_LEN,
		DMG_RIFF_LEN,
		DMG_SHORT_BODY,
		DMG_HUGE_LEN
	} damage_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [7:0]                 s_tdata = 8'd0;   // [7:0] file_byte
	logic                       s_tlast = 1'b0;   // last_byte
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [63:0]                m_tdata;          // [1:0] status, [25:2] committed_bytes,
	                                              // [57:26] crc_value, [63:58] zero
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [whc_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0]                pwdata = 32'd0;
	logic [31:0]                prdata;
	logic                       pready;
	int                         mismatches;
	int                         pending_results;
	int                         send_idle_pct = 0;
	int                         recv_stall_pct = 0;
	int                         quiet_cycles = 0;
	logic [7:0]                 file_q [$];

	wav_header_check_crc32 dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	wav_header_check_crc32_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.mismatches(mismatches), .pending_results(pending_results)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: cycles with no transaction on any port
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Register write; called at a falling edge
	task automatic write_reg(input logic [whc_pkg::ADDR_W-1:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// One byte transaction with random sender gaps
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_file();
		foreach (file_q[i])
			send_byte(file_q[i], i == file_q.size() - 1);
	endtask

	// Hold off input until every verdict has come out, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_results != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_le(input int pos, input logic [31:0] value, input int nbytes);
		for (int i = 0; i < nbytes; i++)
			file_q[pos + i] = value[8*i +: 8];
	endtask

	task automatic set_lengths(input logic [31:0] dlen);
		set_le(4, dlen + 32'd36, 4);
		set_le(40, dlen, 4);
	endtask

	task automatic make_bytes(input int len, input logic rand_fill, input logic [7:0] value);
		file_q.delete();
		repeat (len) file_q.push_back(rand_fill ? 8'($urandom) : value);
	endtask

	// Canonical header followed by body_len random bytes
	task automatic make_wav(input logic [31:0] dlen, input int body_len);
		make_bytes(whc_pkg::HEADER_BYTES + body_len, 1'b1, 8'd0);
		set_le(0, TAG_RIFF, 4);
		set_le(8, TAG_WAVE, 4);
		set_le(12, TAG_FMT, 4);
		set_le(16, 32'd16, 4);
		set_le(20, 32'd1, 2);
		set_le(22, 32'd1, 2);
		set_le(24, RATE_HZ, 4);
		set_le(28, AVG_BPS, 4);
		set_le(32, 32'd2, 2);
		set_le(34, 32'd16, 2);
		set_le(36, TAG_DATA, 4);
		set_lengths(dlen);
	endtask

	task automatic damage_header(input damage_t kind, input logic [31:0] dlen);
		int pos;
		case (kind)
			DMG_BIT_FLIP: begin
				pos = $urandom_range(whc_pkg::HEADER_BYTES - 1);
				file_q[pos] = file_q[pos] ^ (8'd1 << $urandom_range(7));
			end
			DMG_ODD_LEN:  set_lengths(dlen - 32'd1);
			DMG_ZERO_LEN: set_lengths(32'd0);
			DMG_RIFF_LEN: set_le(4, dlen + 32'd34 + 32'd4 * $urandom_range(1), 4);
			DMG_SHORT_BODY: begin
				repeat ($urandom_range(1, dlen)) file_q.delete(file_q.size() - 1);
			end
			default: set_lengths(32'hFFFF_FFFE);
		endcase
	endtask

	// Mostly WAV files with random samples; some damaged, some plain noise
	task automatic random_file();
		int pick;
		int dlen;
		pick = $urandom_range(99);
		if (pick < 70) begin
			dlen = 2 * $urandom_range(1, 24);
			make_wav(dlen, dlen + (($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0));
			if ($urandom_range(9) < 3)
				damage_header(damage_t'($urandom_range(DMG_HUGE_LEN)), dlen);
		end else if (pick < 85) begin
			make_bytes($urandom_range(1, whc_pkg::HEADER_BYTES - 1), 1'b1, 8'd0);
		end else begin
			make_bytes($urandom_range(whc_pkg::HEADER_BYTES, 90), 1'b1, 8'd0);
		end
	endtask

	initial begin
		int items;
		int files;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed files at the reset size limit
		send_idle_pct = 20;
		recv_stall_pct = 20;
		make_bytes(1, 1'b0, 8'hFF);
		send_file();
		make_bytes(whc_pkg::HEADER_BYTES - 1, 1'b1, 8'd0);
		send_file();
		make_bytes(whc_pkg::HEADER_BYTES, 1'b0, 8'h00);
		send_file();
		make_bytes(whc_pkg::HEADER_BYTES, 1'b0, 8'hFF);
		send_file();
		make_wav(2, 2);
		file_q[whc_pkg::HEADER_BYTES] = 8'h00;
		file_q[whc_pkg::HEADER_BYTES + 1] = 8'hFF;
		send_file();
		make_wav(6, 17);
		send_file();
		make_wav(8, 8);
		damage_header(DMG_ODD_LEN, 8);
		send_file();
		make_wav(8, 0);
		damage_header(DMG_ZERO_LEN, 8);
		send_file();
		make_wav(8, 8);
		damage_header(DMG_RIFF_LEN, 8);
		send_file();
		make_wav(20, 20);
		damage_header(DMG_SHORT_BODY, 20);
		send_file();
		make_wav(8, 8);
		damage_header(DMG_HUGE_LEN, 8);
		send_file();
		make_wav(8, 8);
		damage_header(DMG_BIT_FLIP, 8);
		send_file();

		// Smallest limit: a header-only file passes the size check, a file two bytes longer fails it
		drain();
		write_reg(MAX_FILE_ADDR, 32'd44);
		make_wav(2, 0);
		send_file();
		make_wav(2, 2);
		send_file();
		drain();
		write_reg(MAX_FILE_ADDR, 32'd46);
		make_wav(2, 2);
		send_file();
		drain();
		write_reg(MAX_FILE_ADDR, 32'hFF_FFFF);
		make_wav(30, 30);
		send_file();

		// Random phases, each with its own idling pattern and size limit
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					write_reg(MAX_FILE_ADDR, 32'hFF_FFFF);
				end
				1: begin
					send_idle_pct = 76;
					recv_stall_pct = 0;
					write_reg(MAX_FILE_ADDR, $urandom_range(50, 100));
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 76;
					write_reg(MAX_FILE_ADDR, 32'(whc_pkg::MAX_FILE_RESET));
				end
				default: begin
					send_idle_pct = 32;
					recv_stall_pct = 32;
					write_reg(MAX_FILE_ADDR, $urandom_range(70, 130));
				end
			endcase
			items = 0;
			files = 0;
			while (items < PHASE_BYTES || files < PHASE_FILES) begin
				random_file();
				items += file_q.size();
				files++;
				send_file();
				if ($urandom_range(7) == 0)
					drain();
			end
		end

		drain();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
src/whc_pkg.sv
src/wav_header_check_crc32.sv
tb/wav_header_check_crc32_checker.sv
tb/wav_header_check_crc32_tb.sv
